// File: hdl/rle565_pkg.sv
package rle565_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CHANNEL_ORDER = 3'd0;

  localparam logic [1:0] ORDER_RGB = 2'd0;
  localparam logic [1:0] ORDER_GRB = 2'd1;
  localparam logic [1:0] ORDER_BGR = 2'd2;

  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       final_pixel;
  } pixel_t;

  typedef struct packed {
    logic [15:0] run_length;
    logic [15:0] packed_color;
    logic        image_done;
  } result_t;

  // 5-6-5 packing; the unused order code packs as BGR
  function automatic logic [15:0] pack565(logic [1:0] order, pixel_t px);
    logic [7:0] hi;
    logic [7:0] mid;
    logic [7:0] lo;
    case (order) inside
      ORDER_RGB: begin
        hi  = px.red;
        mid = px.green;
        lo  = px.blue;
      end
      ORDER_GRB: begin
        hi  = px.green;
        mid = px.red;
        lo  = px.blue;
      end
      default: begin
        hi  = px.blue;
        mid = px.green;
        lo  = px.red;
      end
    endcase
    return {hi[7:3], mid[7:2], lo[7:3]};
  endfunction

endpackage

// File: hdl/rle565_stream_if.sv
interface rle565_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/rgb565_run_length_encoder.sv
// Channel  Dir  Handshake            Transaction payload
// in_s     in   valid/ready          red, green, blue, final_pixel
// out_s    out  valid/ready          run_length, packed_color, image_done
// cfg_*    in   APB, pready tied 1   channel_order at byte address 0
//
// One pixel is taken per cycle while in_s.ready is high; the run state
// updates at the accepting edge. Results wait in a 3-entry output queue;
// a pixel is taken while it holds at most one result, so a final pixel
// closing two runs stalls in_s even if the sink drains one result per cycle.
// Reset (rst_n low, synchronous) empties the queue, closes the run and sets
// channel_order to 1. A stalled sink lets results pile up; in_s.ready drops
// once two results are waiting.
module rgb565_run_length_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rle565_stream_if.sink                        in_s,
  rle565_stream_if.source                      out_s,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [rle565_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rle565_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rle565_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned QDEPTH = 3;

  // configuration register
  logic [1:0] order_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == rle565_pkg::ADDR_CHANNEL_ORDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= rle565_pkg::ORDER_GRB;
    end else if (cfg_wr) begin
      order_r <= cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == rle565_pkg::ADDR_CHANNEL_ORDER) begin
      cfg_prdata[1:0] = order_r;
    end
  end

  // run state
  logic [15:0] run_cnt_r, run_cnt_nxt;
  logic [15:0] run_col_r, run_col_nxt;

  // output queue, entry 0 is the head
  rle565_pkg::result_t q_r   [QDEPTH];
  rle565_pkg::result_t q_nxt [QDEPTH];
  logic [1:0]          qcnt_r, qcnt_nxt;

  logic                in_acc, out_acc;
  logic [15:0]         color;
  logic                extend;
  logic [15:0]         merged_cnt;
  logic [15:0]         merged_col;
  rle565_pkg::result_t res0, res1;
  logic [1:0]          nres;
  logic [1:0]          base;

  assign in_s.ready  = (qcnt_r <= 2'd1);
  assign in_acc      = in_s.valid && in_s.ready;
  assign out_s.valid = (qcnt_r != 2'd0);
  assign out_s.data  = q_r[0];
  assign out_acc     = out_s.valid && out_s.ready;

  // run compare and increment
  always_comb begin
    color  = rle565_pkg::pack565(order_r, in_s.data);
    extend = (run_cnt_r != 16'd0) && (color == run_col_r)
             && (run_cnt_r != rle565_pkg::RUN_MAX);
    merged_cnt = extend ? run_cnt_r + 16'd1 : 16'd1;
    merged_col = extend ? run_col_r : color;

    res0 = '{run_length: run_cnt_r, packed_color: run_col_r, image_done: 1'b0};
    res1 = '{run_length: merged_cnt, packed_color: merged_col, image_done: 1'b1};
    nres = 2'd0;
    if (!extend && (run_cnt_r != 16'd0)) begin
      nres = 2'd1;
      if (in_s.data.final_pixel) begin
        nres = 2'd2;
      end
    end else if (in_s.data.final_pixel) begin
      // only the flush: move it to the first slot
      res0 = res1;
      nres = 2'd1;
    end
    if (!in_acc) begin
      nres = 2'd0;
    end

    run_cnt_nxt = run_cnt_r;
    run_col_nxt = run_col_r;
    if (in_acc) begin
      run_col_nxt = merged_col;
      run_cnt_nxt = in_s.data.final_pixel ? 16'd0 : merged_cnt;
    end
  end

  // queue update: shift on pop, append new results behind survivors
  always_comb begin
    base     = qcnt_r - {1'b0, out_acc};
    qcnt_nxt = base + nres;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (out_acc) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if ((nres != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = res0;
      end
      if ((nres == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      run_col_r <= '0;
      qcnt_r    <= '0;
    end else begin
      run_cnt_r <= run_cnt_nxt;
      run_col_r <= run_col_nxt;
      qcnt_r    <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // checks
  a_final_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_s.data.final_pixel |=> run_cnt_r == 16'd0)
    else $error("run still open after final pixel");

  a_pixel_opens_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_s.data.final_pixel |=> run_cnt_r != 16'd0)
    else $error("no open run after a plain pixel");

  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> out_s.data.run_length != 16'd0)
    else $error("zero-length run at output");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_s.data.final_pixel |=> qcnt_r != 2'd0)
    else $error("flush result missing from queue");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (qcnt_r == 2'd0) && (run_cnt_r == 16'd0))
    else $error("reset left state behind");

endmodule

// File: tb/tb_rgb565_run_length_encoder.sv
module tb_rgb565_run_length_encoder;

  localparam int unsigned CFG_ADDR_W = rle565_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W = rle565_pkg::CFG_DATA_W;

  // Spare order code: not named in the package, packs like BGR
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  // Watchdog in clock cycles, well above a run with every sink stall at its longest
  localparam int CYCLE_LIMIT = 1_500_000;

  // Cycles allowed after the last run arrives before touching the register
  localparam int SETTLE_CYCLES = 8;

  // Tracks the open run and holds the (length, color) pairs the encoder
  // must produce, oldest first.
  class run_scoreboard;
    logic [1:0]          order;
    logic [15:0]         open_len;
    logic [15:0]         open_color;
    rle565_pkg::result_t expected_runs[$];
    int                  errors;

    function new();
      order      = rle565_pkg::ORDER_GRB;
      open_len   = '0;
      open_color = '0;
      errors     = 0;
    endfunction

    function logic [15:0] pack_color(rle565_pkg::pixel_t px);
      case (order)
        rle565_pkg::ORDER_RGB: return {px.red[7:3], px.green[7:2], px.blue[7:3]};
        rle565_pkg::ORDER_GRB: return {px.green[7:3], px.red[7:2], px.blue[7:3]};
        default:               return {px.blue[7:3], px.green[7:2], px.red[7:3]};
      endcase
    endfunction

    function void push_run(logic [15:0] len, logic [15:0] color, logic done);
      rle565_pkg::result_t r;
      r.run_length   = len;
      r.packed_color = color;
      r.image_done   = done;
      expected_runs.push_back(r);
    endfunction

    // One accepted pixel: extend the run, or close it and start a new one
    function void note_pixel(rle565_pkg::pixel_t px);
      logic [15:0] color;
      color = pack_color(px);
      if (open_len != 0 && color == open_color && open_len != rle565_pkg::RUN_MAX) begin
        open_len = open_len + 16'd1;
      end else begin
        if (open_len != 0) push_run(open_len, open_color, 1'b0);
        open_color = color;
        open_len   = 16'd1;
      end
      if (px.final_pixel) begin
        push_run(open_len, open_color, 1'b1);
        open_len = '0;
      end
    endfunction

    function void check_run(rle565_pkg::result_t got);
      rle565_pkg::result_t want;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected run len=%0d color=%h done=%0b", $time,
                 got.run_length, got.packed_color, got.image_done);
        return;
      end
      want = expected_runs.pop_front();
      if (got.run_length !== want.run_length) begin
        errors++;
        $display("%0t: run_length expected %0d got %0d", $time,
                 want.run_length, got.run_length);
      end
      if (got.packed_color !== want.packed_color) begin
        errors++;
        $display("%0t: packed_color expected %h got %h", $time,
                 want.packed_color, got.packed_color);
      end
      if (got.image_done !== want.image_done) begin
        errors++;
        $display("%0t: image_done expected %0b got %0b", $time,
                 want.image_done, got.image_done);
      end
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rle565_stream_if #(.T(rle565_pkg::pixel_t))  pix_if ();
  rle565_stream_if #(.T(rle565_pkg::result_t)) run_if ();

  run_scoreboard runs = new();

  // Random idling on both channels; cleared for stretches of full throughput
  bit gaps_on;
  int cycle_count;

  rgb565_run_length_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (pix_if.sink),
    .out_s       (run_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Monitor: both channels sampled at the edge, before any update lands.
  // A run can only leave after the pixel that closed it was taken, so the
  // order of the two checks within one edge does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (run_if.valid && run_if.ready) runs.check_run(run_if.data);
      if (pix_if.valid && pix_if.ready) runs.note_pixel(pix_if.data);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_rgb565_run_length_encoder: done, errors");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sink: ready high for a while, then a stall of random length
  initial begin
    int stretch;
    int stall;
    run_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stretch = gaps_on ? $urandom_range(1, 10) : 1;
      stall   = pick_gap();
      run_if.ready <= 1'b1;
      repeat (stretch) @(posedge clk);
      if (stall > 0) begin
        run_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic rle565_pkg::pixel_t make_pixel(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b, logic last);
    rle565_pkg::pixel_t px;
    px.red         = r;
    px.green       = g;
    px.blue        = b;
    px.final_pixel = last;
    return px;
  endfunction

  // Components lean toward the extremes now and then
  function automatic logic [7:0] rand_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a clock edge; returns at the edge where the transaction took place
  task automatic send_pixel(input rle565_pkg::pixel_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= px;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr,
                          output logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_order_readback(input logic [1:0] want);
    logic [CFG_DATA_W-1:0] got;
    apb_read(rle565_pkg::ADDR_CHANNEL_ORDER, got);
    if (got !== CFG_DATA_W'(want)) begin
      runs.errors++;
      $display("%0t: channel_order readback expected %0d got %0d", $time, want, got);
    end
  endtask

  // Drop valid, let every pending run drain, then wait SETTLE_CYCLES so
  // nothing is still in flight inside the encoder. The first edge lets the
  // monitor note the last pixel before the count is read.
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (runs.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drains the encoder before the write; an open run may still be held,
  // which is how an order change in the middle of a run is exercised.
  task automatic set_order(input logic [1:0] code);
    drain();
    apb_write(rle565_pkg::ADDR_CHANNEL_ORDER, CFG_DATA_W'(code));
    runs.order = code;
    check_order_readback(code);
  endtask

  initial begin
    logic [1:0]         order_seq[4];
    rle565_pkg::pixel_t cur;
    rle565_pkg::pixel_t px;
    int                 r;

    order_seq = '{rle565_pkg::ORDER_RGB, ORDER_SPARE, rle565_pkg::ORDER_BGR,
                  rle565_pkg::ORDER_GRB};

    rst_n        <= 1'b0;
    gaps_on       = 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of the order register
    check_order_readback(rle565_pkg::ORDER_GRB);

    // ---- Directed, reset order (green-red swapped) ----
    // Black run of two closed by white, white image flushed by the final flag
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    // Single-pixel image right after an image end
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b1));
    // Final pixel of a new color: closes the run and flushes itself
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b1));
    // Low bits dropped by the packing: different pixels, same 565 color
    send_pixel(make_pixel(8'h03, 8'h07, 8'h07, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h08, 1'b1));

    // ---- Directed, RGB ----
    set_order(rle565_pkg::ORDER_RGB);
    send_pixel(make_pixel(8'hF8, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hFC, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hF8, 1'b1));
    // Leave a red run open across the next order change
    send_pixel(make_pixel(8'hF8, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'hF8, 8'h00, 8'h00, 1'b0));

    // Order change mid-run: green under the swapped order packs to the same
    // word as red did under RGB, so these pixels extend the open run.
    set_order(rle565_pkg::ORDER_GRB);
    send_pixel(make_pixel(8'h00, 8'hF8, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hF8, 8'h00, 1'b1));

    // BGR and the spare code, which must pack identically
    set_order(rle565_pkg::ORDER_BGR);
    send_pixel(make_pixel(8'hF8, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hF8, 1'b1));
    set_order(ORDER_SPARE);
    send_pixel(make_pixel(8'hF8, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hF8, 1'b1));

    // ---- Random: runs of repeated colors, near-identical colors, noise ----
    for (int blk = 0; blk < 13; blk++) begin
      gaps_on = 1'b1;
      set_order(blk < 4 ? order_seq[blk] : 2'($urandom_range(0, 3)));
      gaps_on = ($urandom_range(0, 3) != 0);
      cur = make_pixel(rand_component(), rand_component(), rand_component(), 1'b0);
      for (int i = 0; i < 150; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // repeat the current color
        end else if (r < 58) begin
          // flip only bits the packing usually drops
          cur.red   = cur.red ^ 8'($urandom_range(0, 7));
          cur.green = cur.green ^ 8'($urandom_range(0, 3));
          cur.blue  = cur.blue ^ 8'($urandom_range(0, 7));
        end else begin
          cur = make_pixel(rand_component(), rand_component(), rand_component(), 1'b0);
        end
        px = cur;
        px.final_pixel = ($urandom_range(0, 24) == 0);
        send_pixel(px);
      end
    end

    // ---- Wind down ----
    gaps_on = 1'b1;
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (runs.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (runs.errors == 0 && runs.pending() == 0) begin
      $display("tb_rgb565_run_length_encoder: done, clean");
    end else begin
      $display("tb_rgb565_run_length_encoder: done, errors");
    end
    $finish;
  end

endmodule
